FILE: hw/rtl/olad_pkg.sv
// Shared types and constants for the ordered list append/delete block.
// Used by the cell, the request/response interfaces and the top level.
`default_nettype none
package olad_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 4;
  localparam int ECNT_W  = 5;

  typedef enum logic [STAT_W-1:0] {
    ST_APPENDED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    ACT_APPEND = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic valid;  // cell holds a list entry
    logic load;   // write the request value into this cell
    logic del;    // a delete request is being accepted
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/olad_req_if.sv
// Request channel of the ordered list block: valid/ready plus action and value.
// Depends on olad_pkg for field widths.
`default_nettype none
interface olad_req_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [olad_pkg::VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/olad_rsp_if.sv
// Response channel of the ordered list block: valid/ready plus status fields.
// Depends on olad_pkg for field widths.
`default_nettype none
interface olad_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [olad_pkg::STAT_W-1:0]   status;
  logic [olad_pkg::POS_W-1:0]    position;
  logic [olad_pkg::ECNT_W-1:0]   entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ordered_list_append_delete_core.sv
// Top level of the ordered list block: row of olad_cell, count and response register.
// Depends on olad_pkg, olad_req_if, olad_rsp_if and olad_cell.
`default_nettype none
//
//   channel | direction | payload                           | handshake
//   --------+-----------+-----------------------------------+-------------
//   req     | in        | action, value                     | valid/ready
//   rsp     | out       | status, position, entry_count     | valid/ready
//
// Every request is resolved in a single pass: all cells compare against the value
// in parallel, a found flag ripples down the row, and cells at and past the
// first match take their neighbor's entry in the same edge. One request per
// cycle while rsp is taken; the single response register sets the rate.
// Reset clears the entry count and the response valid; cell contents stay
// undefined and are never read until written. A stalled rsp holds its
// response and backpressures req until it is taken.
module ordered_list_append_delete_core (
  input  wire logic clk,
  input  wire logic rst,
  olad_req_if.sink   req,
  olad_rsp_if.source rsp
);

  localparam int DEPTH = olad_pkg::DEPTH;
  localparam int IDX_W = olad_pkg::IDX_W;
  localparam int CNT_W = olad_pkg::CNT_W;

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         fire;
  logic                         full;
  logic                         is_delete;
  logic [DEPTH:0]               found;
  logic [DEPTH-1:0]             hit;
  logic [olad_pkg::VALUE_W-1:0] cell_data [DEPTH];
  olad_pkg::cell_ctrl_t         ctrl [DEPTH];
  logic [IDX_W-1:0]             hit_pos;

  logic                         rsp_valid;
  olad_pkg::status_t            rsp_status;
  olad_pkg::status_t            status_next;
  logic [olad_pkg::POS_W-1:0]   rsp_position;
  logic [olad_pkg::ECNT_W-1:0]  rsp_entry_count;

  // Accept whenever the response slot is free or being drained
  assign req.ready = !rsp_valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign is_delete = (req.action == olad_pkg::ACT_DELETE);
  assign found[0]  = 1'b0;

  // Row of cells; found ripples from head to tail
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].valid = (CNT_W'(i) < count);
    assign ctrl[i].load  = fire && !is_delete && !full && (CNT_W'(i) == count);
    assign ctrl[i].del   = fire && is_delete;

    olad_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[i]),
      .value     (req.value),
      .next_data ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i + 1) % DEPTH]),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .hit       (hit[i]),
      .data      (cell_data[i])
    );
  end

  // At most one hit bit is set: encode it by OR-ing indexes
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        hit_pos = hit_pos | IDX_W'(i);
      end
    end
  end

  // Decide status and next count
  always_comb begin
    count_next  = count;
    status_next = olad_pkg::ST_APPENDED;
    if (!is_delete) begin
      if (full) begin
        status_next = olad_pkg::ST_FULL;
      end else begin
        count_next  = count + CNT_W'(1);
      end
    end else if (count == '0) begin
      status_next = olad_pkg::ST_EMPTY;
    end else if (found[DEPTH]) begin
      status_next = olad_pkg::ST_DELETED;
      count_next  = count - CNT_W'(1);
    end else begin
      status_next = olad_pkg::ST_NOT_FOUND;
    end
  end

  // Count and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (fire) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload: hold until the next accepted request
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_status      <= status_next;
      rsp_position    <= (status_next == olad_pkg::ST_DELETED) ?
                         olad_pkg::POS_W'(hit_pos) : '0;
      rsp_entry_count <= olad_pkg::ECNT_W'(count_next);
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.position    = rsp_position;
  assign rsp.entry_count = rsp_entry_count;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count exceeds depth");

  a_hit_onehot : assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("more than one cell claims first match");

  a_append_grows : assert property (@(posedge clk) disable iff (rst)
    fire && !is_delete && !full |=> count == $past(count) + CNT_W'(1))
    else $error("append did not grow the list");

  a_delete_shrinks : assert property (@(posedge clk) disable iff (rst)
    fire && is_delete && found[DEPTH] |=> count == $past(count) - CNT_W'(1))
    else $error("delete did not shrink the list");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/olad_cell.sv
// One list cell: holds an entry, compares it to the request value and
// shifts in its right neighbor's entry when a delete closes a gap. Uses olad_pkg.
`default_nettype none
module olad_cell (
  input  wire logic                          clk,
  input  wire olad_pkg::cell_ctrl_t          ctrl,
  input  wire logic [olad_pkg::VALUE_W-1:0]  value,
  input  wire logic [olad_pkg::VALUE_W-1:0]  next_data,
  input  wire logic                          found_in,
  output logic                               found_out,
  output logic                               hit,
  output logic [olad_pkg::VALUE_W-1:0]       data
);

  logic match;

  assign match     = ctrl.del && ctrl.valid && (data == value);
  assign hit       = match && !found_in;
  assign found_out = found_in || match;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= value;
    end else if (ctrl.del && (found_in || match)) begin
      data <= next_data;
    end
  end

endmodule
`default_nettype wire
